FILE: hw/rtl/fpnr_pkg.sv
// fpnr_pkg: shared constants and helpers for the newton reciprocal divide unit
// no dependencies; imported by every module of the block
package fpnr_pkg;

  localparam logic [31:0] MAGIC_GUESS = 32'h7EF311C3;
  localparam logic [31:0] SIGN_BIT    = 32'h80000000;
  localparam logic [31:0] MAG_MASK    = 32'h7FFFFFFF;
  localparam logic [31:0] CANON_NAN   = 32'h7FC00000;
  localparam logic [31:0] FP_TWO      = 32'h40000000;
  localparam logic [7:0]  EXP_ALL     = 8'hFF;

  // pipeline depths of the arithmetic units
  localparam int MUL_LAT    = 3;
  localparam int ADD_LAT    = 3;
  localparam int NEWTON_LAT = 2 * MUL_LAT + ADD_LAT;
  // side delay line covers the input register, three newton steps and the final multiply
  localparam int SIDE_LAT   = 1 + 3 * NEWTON_LAT + MUL_LAT;

  // leading zero count of a 48-bit word, 48 when all zero
  function automatic logic [5:0] clz48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/fpnr_mul.sv
// fpnr_mul: three stage ieee single multiplier, round to nearest even, subnormals kept
// depends on fpnr_pkg
module fpnr_mul import fpnr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_valid,
  output logic [31:0] y
);

  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  // stage 1 registers
  logic               s1_valid;
  logic               s1_sign, s1_nan, s1_inf, s1_zero;
  logic [47:0]        s1_prod;
  logic signed [10:0] s1_exp;
  // stage 2 registers
  logic               s2_valid;
  logic               s2_sign, s2_nan, s2_inf, s2_zero;
  logic [47:0]        s2_norm;
  logic signed [10:0] s2_exp;
  // stage 3 registers
  logic               s3_valid;
  logic [31:0]        s3_y;

  logic [5:0]         lz;
  logic signed [10:0] rsh_full;
  logic [5:0]         rsh;
  logic               normal, ovf, g, st, up;
  logic [111:0]       wide;
  logic [7:0]         efield;
  logic [30:0]        rounded;
  logic [31:0]        y_next;

  // unpack operands
  always_comb begin
    ea     = a[30:23];
    eb     = b[30:23];
    ma     = {ea != 8'd0, a[22:0]};
    mb     = {eb != 8'd0, b[22:0]};
    a_nan  = (ea == EXP_ALL) && (a[22:0] != 23'd0);
    b_nan  = (eb == EXP_ALL) && (b[22:0] != 23'd0);
    a_inf  = (ea == EXP_ALL) && (a[22:0] == 23'd0);
    b_inf  = (eb == EXP_ALL) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
  end

  // stage 1: significand product and biased exponent
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_sign <= a[31] ^ b[31];
      s1_nan  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      s1_inf  <= a_inf | b_inf;
      s1_zero <= a_zero | b_zero;
      s1_prod <= ma * mb;
      s1_exp  <= 11'(signed'({3'b000, (ea == 8'd0) ? 8'd1 : ea}))
               + 11'(signed'({3'b000, (eb == 8'd0) ? 8'd1 : eb})) - 11'sd126;
    end
  end

  // stage 2: normalize so the leading one sits at the top
  assign lz = clz48(s1_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_sign <= s1_sign;
      s2_nan  <= s1_nan;
      s2_inf  <= s1_inf;
      s2_zero <= s1_zero;
      s2_norm <= s1_prod << lz;
      s2_exp  <= s1_exp - 11'(signed'({5'b00000, lz}));
    end
  end

  // stage 3: subnormal shift, rounding and packing
  always_comb begin
    normal   = s2_exp > 11'sd0;
    ovf      = s2_exp > 11'sd254;
    rsh_full = 11'sd1 - s2_exp;
    if (normal) begin
      rsh = 6'd0;
    end else if (rsh_full > 11'sd63) begin
      rsh = 6'd63;
    end else begin
      rsh = rsh_full[5:0];
    end
    wide    = {s2_norm, 64'd0} >> rsh;
    g       = wide[87];
    st      = |wide[86:0];
    up      = g & (st | wide[88]);
    efield  = normal ? s2_exp[7:0] : 8'd0;
    rounded = {efield, wide[110:88]} + {30'd0, up};
    if (s2_nan) begin
      y_next = CANON_NAN;
    end else if (s2_inf || (ovf && !s2_zero)) begin
      y_next = {s2_sign, EXP_ALL, 23'd0};
    end else if (s2_zero) begin
      y_next = {s2_sign, 31'd0};
    end else begin
      y_next = {s2_sign, rounded};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
    if (en) begin
      s3_y <= y_next;
    end
  end

  assign out_valid = s3_valid;
  assign y         = s3_y;

endmodule

FILE: hw/rtl/fpnr_add.sv
// fpnr_add: three stage ieee single adder, round to nearest even, subnormals kept
// depends on fpnr_pkg
module fpnr_add import fpnr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_valid,
  output logic [31:0] y
);

  logic [31:0] big, sml;
  logic [7:0]  e_big, e_sml, diff;
  logic [4:0]  dc;
  logic [52:0] sml_w;
  logic [26:0] sml_x;
  logic        a_nan, b_nan, a_inf, b_inf;

  // stage 1 registers
  logic        s1_valid, s1_sign, s1_sub, s1_nan, s1_inf, s1_inf_sign;
  logic [26:0] s1_big, s1_sml;
  logic [8:0]  s1_exp;
  // stage 2 registers
  logic        s2_valid, s2_sign, s2_nan, s2_inf, s2_zero;
  logic [26:0] s2_n;
  logic [8:0]  s2_exp;
  // stage 3 registers
  logic        s3_valid;
  logic [31:0] s3_y;

  logic [27:0] sum;
  logic [5:0]  lz, lsh;
  logic [8:0]  limit;
  logic [26:0] n_next;
  logic [8:0]  exp_next;
  logic [7:0]  efield;
  logic        up;
  logic [30:0] rounded;
  logic [31:0] y_next;

  // stage 1: order by magnitude and align the smaller operand
  always_comb begin
    a_nan = (a[30:23] == EXP_ALL) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == EXP_ALL) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == EXP_ALL) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == EXP_ALL) && (b[22:0] == 23'd0);
    if (b[30:0] > a[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    diff  = e_big - e_sml;
    dc    = (diff > 8'd31) ? 5'd31 : diff[4:0];
    sml_w = {(sml[30:23] != 8'd0), sml[22:0], 29'd0} >> dc;
    sml_x = {sml_w[52:27], sml_w[26] | (|sml_w[25:0])};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_sign     <= big[31];
      s1_sub      <= a[31] ^ b[31];
      s1_nan      <= a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
      s1_inf      <= a_inf | b_inf;
      s1_inf_sign <= a_inf ? a[31] : b[31];
      s1_big      <= {(big[30:23] != 8'd0), big[22:0], 3'b000};
      s1_sml      <= sml_x;
      s1_exp      <= {1'b0, e_big};
    end
  end

  // stage 2: add or subtract, then normalize without going below the minimum exponent
  always_comb begin
    sum   = s1_sub ? ({1'b0, s1_big} - {1'b0, s1_sml}) : ({1'b0, s1_big} + {1'b0, s1_sml});
    lz    = clz48({sum[26:0], 21'd0});
    limit = s1_exp - 9'd1;
    lsh   = ({3'b000, lz} > limit) ? limit[5:0] : lz;
    if (sum[27]) begin
      n_next   = {sum[27:2], sum[1] | sum[0]};
      exp_next = s1_exp + 9'd1;
    end else begin
      n_next   = sum[26:0] << lsh;
      exp_next = s1_exp - {3'b000, lsh};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_nan  <= s1_nan;
      s2_inf  <= s1_inf;
      s2_zero <= (sum == 28'd0);
      // exact cancellation gives plus zero, matching zeros keep their sign
      if (s1_inf) begin
        s2_sign <= s1_inf_sign;
      end else if (sum == 28'd0) begin
        s2_sign <= s1_sub ? 1'b0 : s1_sign;
      end else begin
        s2_sign <= s1_sign;
      end
      s2_n   <= n_next;
      s2_exp <= exp_next;
    end
  end

  // stage 3: round and pack
  always_comb begin
    efield  = s2_n[26] ? s2_exp[7:0] : 8'd0;
    up      = s2_n[2] & (s2_n[1] | s2_n[0] | s2_n[3]);
    rounded = {efield, s2_n[25:3]} + {30'd0, up};
    if (s2_nan) begin
      y_next = CANON_NAN;
    end else if (s2_inf || (s2_exp > 9'd254)) begin
      y_next = {s2_sign, EXP_ALL, 23'd0};
    end else if (s2_zero) begin
      y_next = {s2_sign, 31'd0};
    end else begin
      y_next = {s2_sign, rounded};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
    if (en) begin
      s3_y <= y_next;
    end
  end

  assign out_valid = s3_valid;
  assign y         = s3_y;

endmodule

FILE: hw/rtl/fpnr_newton.sv
// fpnr_newton: one refinement step r' = r * (2 - m * r) as a nine stage pipeline
// depends on fpnr_pkg, fpnr_mul, fpnr_add
module fpnr_newton import fpnr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] r,
  input  logic [31:0] m,
  output logic        out_valid,
  output logic [31:0] r_out,
  output logic [31:0] m_out
);

  localparam int R_DLY = MUL_LAT + ADD_LAT;

  logic        p_valid, d_valid;
  logic [31:0] p, d;
  logic [31:0] r_dly [R_DLY];
  logic [31:0] m_dly [NEWTON_LAT];

  // product m * r
  fpnr_mul u_mul_mr (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .a         (m),
    .b         (r),
    .out_valid (p_valid),
    .y         (p)
  );

  // 2 - m * r
  fpnr_add u_sub (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_valid),
    .a         (FP_TWO),
    .b         (p ^ SIGN_BIT),
    .out_valid (d_valid),
    .y         (d)
  );

  // r times the correction
  fpnr_mul u_mul_rd (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .a         (r_dly[R_DLY-1]),
    .b         (d),
    .out_valid (out_valid),
    .y         (r_out)
  );

  // operand delay lines aligned with the arithmetic stages
  always_ff @(posedge clk) begin
    if (en) begin
      r_dly[0] <= r;
      for (int i = 1; i < R_DLY; i++) begin
        r_dly[i] <= r_dly[i-1];
      end
      m_dly[0] <= m;
      for (int i = 1; i < NEWTON_LAT; i++) begin
        m_dly[i] <= m_dly[i-1];
      end
    end
  end

  assign m_out = m_dly[NEWTON_LAT-1];

endmodule

FILE: hw/rtl/fp32_newton_reciprocal_divide_unit.sv
// fp32_newton_reciprocal_divide_unit: top level of the approximate single precision divider
// depends on fpnr_pkg, fpnr_newton, fpnr_mul
//
// Usage:
//   input channel  in_valid / in_stall carries dividend and divisor (ieee single bit patterns)
//   output channel out_valid / out_stall carries quotient (ieee single bit pattern)
//   a transaction completes at a clock edge with valid high and stall low
// The divisor magnitude is turned into a first reciprocal guess by an integer
// subtraction from a magic constant, refined by three newton steps, and the
// dividend is multiplied by the result; a negative divisor flips the sign and
// any nan result comes out as the canonical quiet nan.
// A transaction passes one input register, three newton steps of nine stages
// each, a three stage final multiply and the output register. Throughput is one
// transaction per cycle unless the receiver stalls; every multiplier and adder
// is a three stage pipeline that takes a new operation each cycle it is
// enabled. When the receiver stalls a valid quotient, the whole pipeline holds
// and in_stall is raised in the same cycle, so nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
module fp32_newton_reciprocal_divide_unit import fpnr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] quotient
);

  logic        en;
  logic        s0_valid;
  logic [31:0] s0_mag, s0_guess;
  logic        n_valid [4];
  logic [31:0] n_r     [4];
  logic [31:0] n_m     [4];
  logic [31:0] a_dly   [SIDE_LAT];
  logic        neg_dly [SIDE_LAT];
  logic        q_valid;
  logic [31:0] q_raw, q_flip, q_next;
  logic        q_reg_valid;
  logic [31:0] q_reg;

  // pipeline advances whenever the output register can move
  assign en       = !q_reg_valid || !out_stall;
  assign in_stall = !en;

  // input register: magnitude and first reciprocal guess
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
    if (en) begin
      s0_mag   <= divisor & MAG_MASK;
      s0_guess <= MAGIC_GUESS - (divisor & MAG_MASK);
    end
  end

  assign n_valid[0] = s0_valid;
  assign n_r[0]     = s0_guess;
  assign n_m[0]     = s0_mag;

  // three refinement steps
  for (genvar k = 0; k < 3; k++) begin : g_step
    fpnr_newton u_newton (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (n_valid[k]),
      .r         (n_r[k]),
      .m         (n_m[k]),
      .out_valid (n_valid[k+1]),
      .r_out     (n_r[k+1]),
      .m_out     (n_m[k+1])
    );
  end

  // dividend and divisor sign ride alongside the refinement
  always_ff @(posedge clk) begin
    if (en) begin
      a_dly[0]   <= dividend;
      neg_dly[0] <= divisor[31];
      for (int i = 1; i < SIDE_LAT; i++) begin
        a_dly[i]   <= a_dly[i-1];
        neg_dly[i] <= neg_dly[i-1];
      end
    end
  end

  // dividend times refined reciprocal
  fpnr_mul u_mul_q (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (n_valid[3]),
    .a         (a_dly[SIDE_LAT-MUL_LAT-1]),
    .b         (n_r[3]),
    .out_valid (q_valid),
    .y         (q_raw)
  );

  // sign flip for a negative divisor, then nan canonicalization
  always_comb begin
    q_flip = neg_dly[SIDE_LAT-1] ? (q_raw ^ SIGN_BIT) : q_raw;
    if ((q_flip[30:23] == EXP_ALL) && (q_flip[22:0] != 23'd0)) begin
      q_next = CANON_NAN;
    end else begin
      q_next = q_flip;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_reg_valid <= 1'b0;
    end else if (en) begin
      q_reg_valid <= q_valid;
    end
    if (en) begin
      q_reg <= q_next;
    end
  end

  assign out_valid = q_reg_valid;
  assign quotient  = q_reg;

endmodule

FILE: tb/fp32_newton_reciprocal_divide_unit_tb.sv
// fp32_newton_reciprocal_divide_unit_tb: self-checking bench for the newton reciprocal divider
// depends on fpnr_pkg and fp32_newton_reciprocal_divide_unit; quotients predicted via double math
module fp32_newton_reciprocal_divide_unit_tb;
  import fpnr_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] dividend;
  logic [31:0] divisor;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] quotient;

  logic [31:0] expected_quotients[$];
  int          mismatch_count;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          hold_off_cycles;

  fp32_newton_reciprocal_divide_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .dividend  (dividend),
    .divisor   (divisor),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .quotient  (quotient)
  );

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // single bit pattern widened exactly to a double
  function automatic real single_to_real(input logic [31:0] s);
    logic [63:0] d;
    logic [22:0] f;
    int          p;
    f = s[22:0];
    d = '0;
    d[63] = s[31];
    if (s[30:23] == EXP_ALL) begin
      d[62:52] = 11'h7FF;
      d[51:0]  = {f, 29'd0};
    end else if (s[30:23] == 8'd0) begin
      if (f != 0) begin
        p = 0;
        for (int i = 0; i < 23; i++) if (f[i]) p = i;
        d[62:52] = 11'(p - 149 + 1023);
        d[51:0]  = 52'({29'd0, f} << (52 - p));
      end
    end else begin
      d[62:52] = 11'(int'(s[30:23]) - 127 + 1023);
      d[51:0]  = {f, 29'd0};
    end
    return $bitstoreal(d);
  endfunction

  // double rounded to single, nearest even, denormals kept
  function automatic logic [31:0] real_to_single(input real r);
    logic [63:0] d;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] bits;
    int          e;
    int          sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF)
      return (d[51:0] != 0) ? CANON_NAN : {d[63], 31'h7F800000};
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    e = int'(d[62:52]) - 1023;
    m = {11'd0, 1'b1, d[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 63) sh = 63;
    q = m >> sh;
    half = 64'd1 << (sh - 1);
    rem = m & ((64'd1 << sh) - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    if (e >= -126) bits = (64'(e + 127 - 1) << 23) + q;
    else bits = q;
    if (bits >= 64'h7F800000) bits = 64'h7F800000;
    return {d[63], bits[30:0]};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    return real_to_single(single_to_real(a) * single_to_real(b));
  endfunction

  function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
    return real_to_single(single_to_real(a) - single_to_real(b));
  endfunction

  // approximate quotient via magic guess and three newton refinements
  function automatic logic [31:0] predict_quotient(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] mag;
    logic [31:0] recip;
    logic [31:0] q;
    mag = b & MAG_MASK;
    recip = MAGIC_GUESS - mag;
    for (int i = 0; i < 3; i++) recip = fmul(recip, fsub(FP_TWO, fmul(mag, recip)));
    q = fmul(a, recip);
    if (b[31]) q = q ^ SIGN_BIT;
    if (q[30:23] == EXP_ALL && q[22:0] != 0) q = CANON_NAN;
    return q;
  endfunction

  // random operand biased toward interesting exponents
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(7))
      4: v[30:23] = 8'($urandom_range(154, 100));
      5: v[30:23] = $urandom_range(1) ? EXP_ALL : 8'd0;
      6: v[30:0] = $urandom_range(1) ? 31'h3F800000 : 31'(MAGIC_GUESS) + 31'($urandom_range(3));
      7: v[30:23] = 8'($urandom_range(254, 240));
      default: ;
    endcase
    return v;
  endfunction

  // one transaction on the input channel, waits for acceptance
  task automatic send_division(input logic [31:0] a, input logic [31:0] b);
    @(negedge clk);
    in_valid <= 1'b1;
    dividend <= a;
    divisor  <= b;
    do @(posedge clk); while (in_stall);
    expected_quotients.push_back(predict_quotient(a, b));
    if ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_quotients.size() != 0) @(posedge clk);
  endtask

  // receiver stall, with a counted hold-off when requested
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // compare each quotient transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_quotients.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected quotient %h", quotient);
      end else begin
        logic [31:0] want;
        want = expected_quotients.pop_front();
        if (quotient !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("quotient mismatch: expected %h actual %h", want, quotient);
        end
      end
    end
  end

  task automatic test_special_operands();
    logic [31:0] divisors[14];
    logic [31:0] dividends[4];
    divisors = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
                 32'h7F800001, 32'h00000001, 32'h807FFFFF, 32'h7F7FFFFF, 32'h3F800000,
                 32'hBF800000, 32'h40400000, 32'h7EF311C4, 32'hFFFFFFFF};
    dividends = '{32'h00000000, 32'h7F800000, 32'h3FC00000, 32'h80000001};
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    foreach (divisors[i]) send_division(dividends[i % 4], divisors[i]);
    send_division(32'hFFFFFFFF, 32'h40000000);
    send_division(32'h7F7FFFFF, 32'h00800000);
    send_division(32'h00000001, 32'h7F000000);
    send_division(32'h80000000, 32'hC0000000);
    send_division(32'h7FC00001, 32'h3F800000);
    wait_drained();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_division(pick_operand(), pick_operand());
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_cycles = 120;
    repeat (80) send_division(pick_operand(), pick_operand());
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    dividend = '0;
    divisor = '0;
    out_stall = 1'b0;
    mismatch_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_special_operands();
    test_random_phase(0, 0, 300);
    test_random_phase(70, 0, 250);
    test_random_phase(0, 70, 250);
    test_random_phase(36, 36, 250);
    test_random_phase(0, 0, 100);
    test_backpressure();
    test_random_phase(20, 20, 300);
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_quotients.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #(12 * 200000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
